>>> hw/rtl/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types and constants of the dust sensor frame parser.
// ----------------------------------------------------------------------------
package dsfp_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hAA;
	localparam logic [7:0] CMD_BYTE  = 8'hC0;
	localparam logic [7:0] TAIL_BYTE = 8'hAB;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	localparam logic [2:0] ST_GOOD         = 3'd0;
	localparam logic [2:0] ST_ZERO         = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER   = 3'd2;
	localparam logic [2:0] ST_BAD_COMMAND  = 3'd3;
	localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_BAD_TAIL     = 3'd5;

	localparam logic [3:0] POS_HDR     = 4'd0;
	localparam logic [3:0] POS_CMD     = 4'd1;
	localparam logic [3:0] POS_PM25_LO = 4'd2;
	localparam logic [3:0] POS_PM25_HI = 4'd3;
	localparam logic [3:0] POS_PM10_LO = 4'd4;
	localparam logic [3:0] POS_PM10_HI = 4'd5;
	localparam logic [3:0] POS_DATA_A  = 4'd6;
	localparam logic [3:0] POS_DATA_B  = 4'd7;
	localparam logic [3:0] POS_SUM     = 4'd8;
	localparam logic [3:0] POS_TAIL    = 4'd9;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        fire;
		logic [2:0]  frame_status;
		logic [15:0] pm25_tenths;
		logic [15:0] pm10_tenths;
	} res_t;

endpackage

>>> hw/rtl/dsfp_ifs.sv
// ----------------------------------------------------------------------------
// dsfp channel interfaces
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface dsfp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;
	modport source (output valid, kind, rx_byte, input ready);
	modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface dsfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_status;
	logic [15:0] pm25_tenths;
	logic [15:0] pm10_tenths;
	modport source (output valid, frame_status, pm25_tenths, pm10_tenths, input ready);
	modport sink (input valid, frame_status, pm25_tenths, pm10_tenths, output ready);
endinterface

interface dsfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] idle_timeout_ticks;
	modport source (output valid, idle_timeout_ticks, input ready);
	modport sink (input valid, idle_timeout_ticks, output ready);
endinterface

>>> hw/rtl/dust_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// dust_sensor_frame_parser_unit
// Deframes 10-byte particulate sensor frames from serial bytes and ms ticks.
// ----------------------------------------------------------------------------
// Takes one word per clock: a received byte or a millisecond tick. A word is
// registered on acceptance and decided against the frame state in the next
// cycle; when it ends a frame or is rejected, its result lands in the result
// register at the end of that same cycle. Input keeps flowing while a result
// waits; only a word that ends a frame or is rejected stalls, and only while
// the result register is still full and not being read in that cycle. The
// idle timeout register may be written at any time the unit is idle and is
// always ready.
module dust_sensor_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	dsfp_in_if.sink     rx,
	dsfp_out_if.source  result,
	dsfp_cfg_if.sink    cfg
);

	logic            valid_s1;
	dsfp_pkg::item_t item_s1;
	logic            advance;
	logic            out_free;
	dsfp_pkg::res_t  res;

	dsfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dsfp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.advance  (advance),
		.res      (res)
	);

	dsfp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.result   (result)
	);

	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.fire && item_s1.kind == dsfp_pkg::KIND_TICK))
		else $error("tick produced a result");

	a_fire_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |-> out_free)
		else $error("result overwrote a waiting result");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_status == dsfp_pkg::ST_GOOD) |->
		(result.pm25_tenths != 16'd0 || result.pm10_tenths != 16'd0))
		else $error("good frame reported with both values zero");

	a_bad_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.fire && res.frame_status != dsfp_pkg::ST_GOOD) |->
		(res.pm25_tenths == 16'd0 && res.pm10_tenths == 16'd0))
		else $error("non-good result carries values");

endmodule

>>> hw/rtl/dsfp_in_reg.sv
// ----------------------------------------------------------------------------
// dsfp_in_reg
// Input register stage: holds one accepted word until the parser takes it.
// ----------------------------------------------------------------------------
module dsfp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	dsfp_in_if.sink           rx,
	input  logic              advance,
	output logic              valid_s1,
	output dsfp_pkg::item_t   item_s1
);

	logic take;

	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind    <= rx.kind;
			item_s1.rx_byte <= rx.rx_byte;
		end
	end

endmodule

>>> hw/rtl/dsfp_core.sv
// ----------------------------------------------------------------------------
// dsfp_core
// Frame state, idle tick counter, timeout register and per-word decision.
// ----------------------------------------------------------------------------
module dsfp_core (
	input  logic              clk,
	input  logic              arst_n,
	dsfp_cfg_if.sink          cfg,
	input  logic              valid_s1,
	input  dsfp_pkg::item_t   item_s1,
	input  logic              out_free,
	output logic              advance,
	output dsfp_pkg::res_t    res
);

	logic [15:0] timeout_q;
	logic [3:0]  pos_q;
	logic [7:0]  sum_q;
	logic [15:0] pm25_q;
	logic [15:0] pm10_q;
	logic [15:0] idle_q;

	logic        is_byte;
	logic [3:0]  pos_eff;
	logic        want;
	logic [2:0]  status;
	logic [3:0]  pos_next;
	logic [7:0]  b;

	assign cfg.ready = 1'b1;
	assign is_byte   = item_s1.kind == dsfp_pkg::KIND_BYTE;
	assign b         = item_s1.rx_byte;

	always_comb begin
		if (pos_q != dsfp_pkg::POS_HDR && idle_q >= timeout_q) begin
			pos_eff = dsfp_pkg::POS_HDR;
		end else if (pos_q > dsfp_pkg::POS_TAIL) begin
			pos_eff = dsfp_pkg::POS_HDR;
		end else begin
			pos_eff = pos_q;
		end
	end

	always_comb begin
		want     = 1'b0;
		status   = dsfp_pkg::ST_GOOD;
		pos_next = pos_eff + 4'd1;
		case (pos_eff)
			dsfp_pkg::POS_HDR: begin
				if (b != dsfp_pkg::HDR_BYTE) begin
					want   = 1'b1;
					status = dsfp_pkg::ST_BAD_HEADER;
				end
			end
			dsfp_pkg::POS_CMD: begin
				if (b != dsfp_pkg::CMD_BYTE) begin
					want   = 1'b1;
					status = dsfp_pkg::ST_BAD_COMMAND;
				end
			end
			dsfp_pkg::POS_SUM: begin
				if (b != sum_q) begin
					want   = 1'b1;
					status = dsfp_pkg::ST_BAD_CHECKSUM;
				end
			end
			dsfp_pkg::POS_TAIL: begin
				want = 1'b1;
				if (b != dsfp_pkg::TAIL_BYTE) begin
					status = dsfp_pkg::ST_BAD_TAIL;
				end else if (pm25_q == 16'd0 && pm10_q == 16'd0) begin
					status = dsfp_pkg::ST_ZERO;
				end else begin
					status = dsfp_pkg::ST_GOOD;
				end
			end
			default: begin
			end
		endcase
		if (want) begin
			pos_next = dsfp_pkg::POS_HDR;
		end
		if (!is_byte) begin
			want = 1'b0;
		end
	end

	assign advance          = valid_s1 && (!want || out_free);
	assign res.fire         = advance && want;
	assign res.frame_status = status;
	assign res.pm25_tenths  = (status == dsfp_pkg::ST_GOOD) ? pm25_q : 16'd0;
	assign res.pm10_tenths  = (status == dsfp_pkg::ST_GOOD) ? pm10_q : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= dsfp_pkg::TIMEOUT_RESET;
			pos_q     <= dsfp_pkg::POS_HDR;
			sum_q     <= 8'd0;
			pm25_q    <= 16'd0;
			pm10_q    <= 16'd0;
			idle_q    <= 16'd0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				timeout_q <= cfg.idle_timeout_ticks;
			end
			if (advance) begin
				if (!is_byte) begin
					if (idle_q != 16'hFFFF) begin
						idle_q <= idle_q + 16'd1;
					end
				end else begin
					idle_q <= 16'd0;
					pos_q  <= pos_next;
					case (pos_eff)
						dsfp_pkg::POS_HDR: begin
							if (!want) begin
								sum_q <= 8'd0;
							end
						end
						dsfp_pkg::POS_PM25_LO: begin
							pm25_q[7:0] <= b;
							sum_q       <= sum_q + b;
						end
						dsfp_pkg::POS_PM25_HI: begin
							pm25_q[15:8] <= b;
							sum_q        <= sum_q + b;
						end
						dsfp_pkg::POS_PM10_LO: begin
							pm10_q[7:0] <= b;
							sum_q       <= sum_q + b;
						end
						dsfp_pkg::POS_PM10_HI: begin
							pm10_q[15:8] <= b;
							sum_q        <= sum_q + b;
						end
						dsfp_pkg::POS_DATA_A, dsfp_pkg::POS_DATA_B: begin
							sum_q <= sum_q + b;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

>>> hw/rtl/dsfp_out_reg.sv
// ----------------------------------------------------------------------------
// dsfp_out_reg
// Result register: holds one finished word until the sink takes it.
// ----------------------------------------------------------------------------
module dsfp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  dsfp_pkg::res_t   res,
	output logic             out_free,
	dsfp_out_if.source       result
);

	logic        valid_q;
	logic [2:0]  status_q;
	logic [15:0] pm25_q;
	logic [15:0] pm10_q;

	assign out_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.fire) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			status_q <= res.frame_status;
			pm25_q   <= res.pm25_tenths;
			pm10_q   <= res.pm10_tenths;
		end
	end

	assign result.valid        = valid_q;
	assign result.frame_status = status_q;
	assign result.pm25_tenths  = pm25_q;
	assign result.pm10_tenths  = pm10_q;

endmodule

>>> tb/dust_sensor_frame_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dust_sensor_frame_parser_unit_test
// Drives received bytes and millisecond ticks into the frame parser, runs a
// cycle-free model of the deframer next to it and checks every result word
// against it in order. Covers header, command, checksum and tail faults,
// all-zero frames, idle timeouts at several timeout settings including the
// extremes, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dust_sensor_frame_parser_unit_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int MAX_REPORTS    = 100;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] pm25;
		logic [15:0] pm10;
	} frame_result_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_HEADER,
		FLAW_COMMAND,
		FLAW_CHECKSUM,
		FLAW_TAIL,
		FLAW_SHORT
	} flaw_t;

	logic clk;
	logic arst_n;

	dsfp_in_if  rx_if ();
	dsfp_out_if res_if ();
	dsfp_cfg_if cfg_if ();

	dust_sensor_frame_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	dsfp_pkg::item_t pending_words[$];
	frame_result_t   frames_due[$];
	logic [15:0]     timeout_writes[$];

	// model state
	logic [15:0] idle_limit;
	logic [3:0]  frame_pos;
	logic [7:0]  frame_sum;
	logic [15:0] pm25_acc;
	logic [15:0] pm10_acc;
	logic [15:0] idle_ticks;

	int   words_queued;
	int   burst_left;
	int   gap_left;
	dsfp_pkg::item_t next_word;

	int   mismatches;
	int   cyc;
	int   hold_left;
	int   holds_asked;
	int   holds_done;
	frame_result_t want;
	frame_result_t got;

	int   quiet_cycles = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void parse_word(input logic kind, input logic [7:0] b);
		frame_result_t r;
		logic          done;
		r = '{dsfp_pkg::ST_GOOD, 16'd0, 16'd0};
		done = 1'b0;
		if (kind == dsfp_pkg::KIND_TICK) begin
			if (idle_ticks != 16'hFFFF)
				idle_ticks = idle_ticks + 16'd1;
			return;
		end
		if (frame_pos != dsfp_pkg::POS_HDR && idle_ticks >= idle_limit)
			frame_pos = dsfp_pkg::POS_HDR;
		idle_ticks = 16'd0;
		if (frame_pos > dsfp_pkg::POS_TAIL)
			frame_pos = dsfp_pkg::POS_HDR;
		case (frame_pos)
			dsfp_pkg::POS_HDR: begin
				if (b != dsfp_pkg::HDR_BYTE) begin
					done = 1'b1;
					r.status = dsfp_pkg::ST_BAD_HEADER;
				end else begin
					frame_sum = 8'd0;
				end
			end
			dsfp_pkg::POS_CMD: begin
				if (b != dsfp_pkg::CMD_BYTE) begin
					done = 1'b1;
					r.status = dsfp_pkg::ST_BAD_COMMAND;
				end
			end
			dsfp_pkg::POS_PM25_LO: pm25_acc[7:0] = b;
			dsfp_pkg::POS_PM25_HI: pm25_acc[15:8] = b;
			dsfp_pkg::POS_PM10_LO: pm10_acc[7:0] = b;
			dsfp_pkg::POS_PM10_HI: pm10_acc[15:8] = b;
			dsfp_pkg::POS_SUM: begin
				if (b != frame_sum) begin
					done = 1'b1;
					r.status = dsfp_pkg::ST_BAD_CHECKSUM;
				end
			end
			dsfp_pkg::POS_TAIL: begin
				done = 1'b1;
				if (b != dsfp_pkg::TAIL_BYTE)
					r.status = dsfp_pkg::ST_BAD_TAIL;
				else if (pm25_acc == 16'd0 && pm10_acc == 16'd0)
					r.status = dsfp_pkg::ST_ZERO;
				else
					r = '{dsfp_pkg::ST_GOOD, pm25_acc, pm10_acc};
			end
			default: ;
		endcase
		if (done) begin
			frames_due.push_back(r);
			frame_pos = dsfp_pkg::POS_HDR;
		end else begin
			if (frame_pos >= dsfp_pkg::POS_PM25_LO && frame_pos <= dsfp_pkg::POS_DATA_B)
				frame_sum = frame_sum + b;
			frame_pos = frame_pos + 4'd1;
		end
	endfunction

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.kind <= dsfp_pkg::KIND_BYTE;
			rx_if.rx_byte <= 8'd0;
			burst_left = 0;
			gap_left = 0;
			frame_pos = dsfp_pkg::POS_HDR;
			frame_sum = 8'd0;
			pm25_acc = 16'd0;
			pm10_acc = 16'd0;
			idle_ticks = 16'd0;
		end else begin
			if (rx_if.valid && rx_if.ready)
				parse_word(rx_if.kind, rx_if.rx_byte);
			if (!rx_if.valid || rx_if.ready) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
					rx_if.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					rx_if.valid <= 1'b1;
					rx_if.kind <= next_word.kind;
					rx_if.rx_byte <= next_word.rx_byte;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_if.valid <= 1'b0;
			cfg_if.idle_timeout_ticks <= dsfp_pkg::TIMEOUT_RESET;
			idle_limit <= dsfp_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				idle_limit <= cfg_if.idle_timeout_ticks;
			if (!cfg_if.valid || cfg_if.ready) begin
				if (timeout_writes.size() != 0) begin
					cfg_if.valid <= 1'b1;
					cfg_if.idle_timeout_ticks <= timeout_writes.pop_front();
				end else begin
					cfg_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern, long hold on request, result checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			cyc = 0;
			hold_left = 0;
			holds_done = 0;
			mismatches = 0;
		end else begin
			cyc = cyc + 1;
			if (res_if.valid && res_if.ready) begin
				got = '{res_if.frame_status, res_if.pm25_tenths, res_if.pm10_tenths};
				if (frames_due.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected word: status %0d pm25 %0d pm10 %0d",
							$time, got.status, got.pm25, got.pm10);
				end else begin
					want = frames_due.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: exp st %0d pm25 %0d pm10 %0d, got st %0d pm25 %0d pm10 %0d",
								$time, want.status, want.pm25, want.pm10,
								got.status, got.pm25, got.pm10);
					end
				end
				if (holds_done != holds_asked) begin
					holds_done = holds_done + 1;
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				res_if.ready <= 1'b0;
			end else begin
				case (cyc[10:9])
					2'd0: res_if.ready <= 1'b1;
					2'd1: res_if.ready <= ($urandom_range(0, 3) != 0);
					2'd2: res_if.ready <= $urandom_range(0, 1);
					default: res_if.ready <= (cyc[1:0] == 2'd0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic put_word(input logic kind, input logic [7:0] b);
		dsfp_pkg::item_t w;
		w.kind = kind;
		w.rx_byte = b;
		pending_words.push_back(w);
		words_queued = words_queued + 1;
	endtask

	task automatic put_ticks(input int n);
		for (int i = 0; i < n; i++)
			put_word(dsfp_pkg::KIND_TICK, 8'($urandom));
	endtask

	task automatic put_frame(input logic [15:0] pm25, input logic [15:0] pm10,
			input logic [7:0] d6, input logic [7:0] d7, input flaw_t flaw,
			input int tick_span);
		logic [7:0] fb[10];
		logic [7:0] sum;
		int         len;
		fb[0] = dsfp_pkg::HDR_BYTE;
		fb[1] = dsfp_pkg::CMD_BYTE;
		fb[2] = pm25[7:0];
		fb[3] = pm25[15:8];
		fb[4] = pm10[7:0];
		fb[5] = pm10[15:8];
		fb[6] = d6;
		fb[7] = d7;
		sum = 8'd0;
		for (int i = 2; i < 8; i++)
			sum = sum + fb[i];
		fb[8] = sum;
		fb[9] = dsfp_pkg::TAIL_BYTE;
		len = 10;
		case (flaw)
			FLAW_HEADER:   fb[0] = dsfp_pkg::HDR_BYTE ^ 8'($urandom_range(1, 255));
			FLAW_COMMAND:  fb[1] = dsfp_pkg::CMD_BYTE ^ 8'($urandom_range(1, 255));
			FLAW_CHECKSUM: fb[8] = sum ^ 8'($urandom_range(1, 255));
			FLAW_TAIL:     fb[9] = dsfp_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255));
			FLAW_SHORT:    len = $urandom_range(1, 9);
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			if (tick_span > 0 && $urandom_range(0, 7) == 0)
				put_ticks($urandom_range(0, tick_span));
			put_word(dsfp_pkg::KIND_BYTE, fb[i]);
		end
	endtask

	task automatic put_random_frame(input int tick_span);
		logic [15:0] pm25;
		logic [15:0] pm10;
		flaw_t       flaw;
		case ($urandom_range(0, 9))
			0: begin
				pm25 = 16'd0;
				pm10 = 16'd0;
			end
			1: begin
				pm25 = 16'($urandom_range(0, 20));
				pm10 = 16'($urandom_range(0, 20));
			end
			default: begin
				pm25 = 16'($urandom);
				pm10 = 16'($urandom);
			end
		endcase
		case ($urandom_range(0, 15))
			0: flaw = FLAW_HEADER;
			1: flaw = FLAW_COMMAND;
			2: flaw = FLAW_CHECKSUM;
			3: flaw = FLAW_TAIL;
			4: flaw = FLAW_SHORT;
			default: flaw = FLAW_NONE;
		endcase
		put_frame(pm25, pm10, 8'($urandom), 8'($urandom), flaw, tick_span);
	endtask

	task automatic put_random_words(input int count, input int tick_span);
		int start;
		int pick;
		start = words_queued;
		while (words_queued - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				put_random_frame(tick_span);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4))
					put_word(dsfp_pkg::KIND_BYTE, 8'($urandom));
			end else begin
				put_ticks($urandom_range(1, tick_span + 1));
			end
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || rx_if.valid || frames_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		drain();
		timeout_writes.push_back(v);
		do
			@(negedge clk);
		while (timeout_writes.size() != 0 || cfg_if.valid);
	endtask

	initial begin
		arst_n = 1'b0;
		words_queued = 0;
		holds_asked = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, zero frame, ignored tick byte, rejected header value not re-tested
		put_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, FLAW_NONE, 0);
		put_frame(16'h0000, 16'h0000, 8'h00, 8'h00, FLAW_NONE, 0);
		put_word(dsfp_pkg::KIND_TICK, 8'hFF);
		put_word(dsfp_pkg::KIND_BYTE, 8'h00);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::CMD_BYTE);
		put_random_words(300, 4);

		write_timeout(16'd1);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_TICK, 8'h00);
		put_frame(16'h0001, 16'h0000, 8'h00, 8'h00, FLAW_NONE, 0);
		put_random_words(250, 3);

		write_timeout(16'd3);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::CMD_BYTE);
		put_ticks(2);
		put_word(dsfp_pkg::KIND_BYTE, 8'h12);
		put_word(dsfp_pkg::KIND_BYTE, 8'h34);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::CMD_BYTE);
		put_ticks(3);
		put_frame(16'h0200, 16'h0001, 8'h80, 8'h7F, FLAW_NONE, 0);
		holds_asked = holds_asked + 1;
		put_random_words(250, 5);

		write_timeout(16'd0);
		put_frame(16'h1234, 16'h5678, 8'h00, 8'h00, FLAW_NONE, 0);
		put_random_words(100, 2);

		// keep a partial frame across idle ticks with the longest timeout
		write_timeout(16'hFFFF);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::HDR_BYTE);
		put_word(dsfp_pkg::KIND_BYTE, dsfp_pkg::CMD_BYTE);
		put_ticks(40);
		put_frame(16'h00FF, 16'hFF00, 8'h55, 8'hAA, FLAW_NONE, 0);
		put_random_words(250, 12);

		write_timeout(16'($urandom_range(2, 20)));
		holds_asked = holds_asked + 1;
		put_random_words(300, 22);

		write_timeout(dsfp_pkg::TIMEOUT_RESET);
		put_random_words(150, 8);

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dsfp_pkg.sv
hw/rtl/dsfp_ifs.sv
hw/rtl/dsfp_in_reg.sv
hw/rtl/dsfp_core.sv
hw/rtl/dsfp_out_reg.sv
hw/rtl/dust_sensor_frame_parser_unit.sv
tb/dust_sensor_frame_parser_unit_test.sv
